>>> hw/rtl/dtkc_pkg.sv
package dtkc_pkg;

    localparam int DIGITS    = 8;
    localparam int FREQ_W    = 30;
    localparam int IFF_W     = 17;
    localparam int CURSOR_W  = 4;
    localparam int BTN_W     = 5;
    localparam int HOLD_W    = 5;
    localparam int RPT_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = FREQ_W;

    // button bit positions in the stored pattern
    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_ENTER = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IF_FREQ  = 1'd1;

    localparam logic [FREQ_W-1:0]   RST_TUNED_FREQ = FREQ_W'(127100000);
    localparam logic [FREQ_W-1:0]   RST_MAX_FREQ   = FREQ_W'(225000000);
    localparam logic [IFF_W-1:0]    RST_IF_FREQ    = IFF_W'(455);
    localparam logic [CURSOR_W-1:0] CURSOR_MAX     = CURSOR_W'(DIGITS);

    localparam logic [HOLD_W-1:0] HOLD_MAX    = HOLD_W'(31);
    localparam logic [HOLD_W-1:0] HOLD_THRESH = HOLD_W'(30);
    localparam logic [RPT_W-1:0]  RPT_MAX     = RPT_W'(15);
    localparam logic [RPT_W-1:0]  DELAY_SLOW  = RPT_W'(10);
    localparam logic [RPT_W-1:0]  DELAY_FAST  = RPT_W'(5);
    localparam logic [RPT_W-1:0]  FAST_AFTER  = RPT_W'(10);

    typedef logic [FREQ_W-1:0] freq_t;

    // 10^(DIGITS - cursor)
    function automatic freq_t step_size(input logic [CURSOR_W-1:0] cur);
        logic [CURSOR_W-1:0] e;
        freq_t p;
        if (cur > CURSOR_MAX)
            e = '0;
        else
            e = CURSOR_MAX - cur;
        case (e)
            4'd0:    p = FREQ_W'(1);
            4'd1:    p = FREQ_W'(10);
            4'd2:    p = FREQ_W'(100);
            4'd3:    p = FREQ_W'(1000);
            4'd4:    p = FREQ_W'(10000);
            4'd5:    p = FREQ_W'(100000);
            4'd6:    p = FREQ_W'(1000000);
            4'd7:    p = FREQ_W'(10000000);
            4'd8:    p = FREQ_W'(100000000);
            4'd9:    p = FREQ_W'(1000000000);
            default: p = FREQ_W'(1);
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/dtkc_in_if.sv
interface dtkc_in_if;
    logic valid;
    logic ready;
    logic btn_up;
    logic btn_down;
    logic btn_left;
    logic btn_right;
    logic btn_enter;

    modport source (output valid, output btn_up, output btn_down, output btn_left,
                    output btn_right, output btn_enter, input ready);
    modport sink   (input valid, input btn_up, input btn_down, input btn_left,
                    input btn_right, input btn_enter, output ready);
endinterface

>>> hw/rtl/dtkc_out_if.sv
interface dtkc_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] frequency;
    logic [3:0]  digit_position;
    logic        transmit;
    logic [16:0] if_offset;
    logic        updated;

    modport source (output valid, output frequency, output digit_position,
                    output transmit, output if_offset, output updated, input ready);
    modport sink   (input valid, input frequency, input digit_position,
                    input transmit, input if_offset, input updated, output ready);
endinterface

>>> hw/rtl/digit_tuning_keypad_controller_core.sv
// Digit-tuning keypad controller.
//
// in_ch carries one polling tick per request: the five button levels.
// out_ch returns one result per tick: tuned frequency, digit cursor,
// transmit flag, active IF offset and an "updated" flag set when the
// tick ran a button action (edge action or auto-repeat).
// cfg_we/cfg_index/cfg_wdata write max_freq (index 0) and if_freq
// (index 1); write only while no tick is in flight.
//
// Each request is captured in one input register, then the tuning logic
// (step table, one add/subtract and compare) feeds the result register.
// One tick per cycle is sustained while the receiver takes results.
// When the receiver stalls, the result register holds and the input
// register takes one more tick; in_ch.ready drops only when both are full.
// Reset (rst_n low, async) restores 127100000 Hz, cursor 0, receive mode
// with offset inactive, cleared repeat counters and the register defaults.
module digit_tuning_keypad_controller_core
    import dtkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    dtkc_in_if.sink               in_ch,
    dtkc_out_if.source            out_ch
);

    logic                s1_valid_reg, s1_valid_next;
    logic [BTN_W-1:0]    s1_btn_reg;
    logic                out_valid_reg, out_valid_next;

    freq_t               max_freq_reg;
    logic [IFF_W-1:0]    if_freq_reg;

    freq_t               tuned_freq_reg, tuned_freq_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic                tx_mode_reg, tx_mode_next;
    logic                offset_active_reg, offset_active_next;
    logic [BTN_W-1:0]    last_buttons_reg, last_buttons_next;
    logic [HOLD_W-1:0]   hold_ticks_reg, hold_ticks_next;
    logic [RPT_W-1:0]    repeat_ticks_reg, repeat_ticks_next;
    logic [RPT_W-1:0]    repeats_done_reg, repeats_done_next;

    freq_t               frequency_reg;
    logic [CURSOR_W-1:0] digit_position_reg;
    logic                transmit_reg;
    logic [IFF_W-1:0]    if_offset_reg;
    logic                updated_reg;
    logic                acted;

    logic in_accept, adv;
    logic up, down, left, right, enter;
    logic change, fire;
    logic do_up, do_down;
    logic [HOLD_W-1:0] hold_base, hold_inc;
    logic [RPT_W-1:0]  rd_base, rt_inc, delay;
    freq_t             step;
    logic [FREQ_W:0]   sum;
    freq_t             up_val, down_val;

    assign adv          = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || adv;
    assign in_accept    = in_ch.valid && in_ch.ready;

    assign up    = s1_btn_reg[BTN_UP];
    assign down  = s1_btn_reg[BTN_DOWN];
    assign left  = s1_btn_reg[BTN_LEFT];
    assign right = s1_btn_reg[BTN_RIGHT];
    assign enter = s1_btn_reg[BTN_ENTER];

    assign step     = step_size(cursor_reg);
    assign sum      = {1'b0, tuned_freq_reg} + {1'b0, step};
    assign up_val   = (sum <= {1'b0, max_freq_reg}) ? sum[FREQ_W-1:0] : max_freq_reg;
    assign down_val = (tuned_freq_reg >= step) ? (tuned_freq_reg - step) : '0;

    always_comb
    begin
        change    = (s1_btn_reg != last_buttons_reg);
        hold_base = change ? '0 : hold_ticks_reg;
        rd_base   = change ? '0 : repeats_done_reg;
        hold_inc  = (hold_base < HOLD_MAX) ? hold_base + HOLD_W'(1) : hold_base;
        rt_inc    = (repeat_ticks_reg < RPT_MAX) ? repeat_ticks_reg + RPT_W'(1)
                                                  : repeat_ticks_reg;
        delay     = (rd_base < FAST_AFTER) ? DELAY_SLOW : DELAY_FAST;

        last_buttons_next = s1_btn_reg;
        hold_ticks_next   = hold_base;
        repeat_ticks_next = repeat_ticks_reg;
        repeats_done_next = rd_base;
        fire              = 1'b0;

        if (s1_btn_reg != '0)
        begin
            hold_ticks_next = hold_inc;
            if (hold_inc > HOLD_THRESH)
            begin
                repeat_ticks_next = rt_inc;
                if (rt_inc >= delay)
                begin
                    fire              = 1'b1;
                    repeat_ticks_next = '0;
                    repeats_done_next = (rd_base < RPT_MAX) ? rd_base + RPT_W'(1) : rd_base;
                end
            end
        end

        // a change clears hold_ticks, so an edge action and a repeat never coincide
        do_up   = (change || fire) && up;
        do_down = (change || fire) && !up && down;

        tuned_freq_next    = tuned_freq_reg;
        cursor_next        = cursor_reg;
        tx_mode_next       = tx_mode_reg;
        offset_active_next = offset_active_reg;

        if (do_up)
            tuned_freq_next = up_val;
        else if (do_down)
            tuned_freq_next = down_val;
        else if (change && right)
        begin
            if (cursor_reg < CURSOR_MAX)
                cursor_next = cursor_reg + CURSOR_W'(1);
        end
        else if (change && left)
        begin
            if (cursor_reg != '0)
                cursor_next = cursor_reg - CURSOR_W'(1);
        end
        else if (change && enter)
        begin
            tx_mode_next       = !tx_mode_reg;
            offset_active_next = tx_mode_reg;
        end

        acted = do_up || do_down || (change && (right || left || enter));
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            max_freq_reg      <= RST_MAX_FREQ;
            if_freq_reg       <= RST_IF_FREQ;
            tuned_freq_reg    <= RST_TUNED_FREQ;
            cursor_reg        <= '0;
            tx_mode_reg       <= 1'b0;
            offset_active_reg <= 1'b0;
            last_buttons_reg  <= '0;
            hold_ticks_reg    <= '0;
            repeat_ticks_reg  <= '0;
            repeats_done_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_FREQ: max_freq_reg <= cfg_wdata[FREQ_W-1:0];
                    CFG_IF_FREQ:  if_freq_reg  <= cfg_wdata[IFF_W-1:0];
                    default: ;
                endcase
            end
            if (adv)
            begin
                tuned_freq_reg    <= tuned_freq_next;
                cursor_reg        <= cursor_next;
                tx_mode_reg       <= tx_mode_next;
                offset_active_reg <= offset_active_next;
                last_buttons_reg  <= last_buttons_next;
                hold_ticks_reg    <= hold_ticks_next;
                repeat_ticks_reg  <= repeat_ticks_next;
                repeats_done_reg  <= repeats_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_btn_reg <= {in_ch.btn_enter, in_ch.btn_right, in_ch.btn_left,
                           in_ch.btn_down, in_ch.btn_up};
        if (adv)
        begin
            frequency_reg      <= tuned_freq_next;
            digit_position_reg <= cursor_next;
            transmit_reg       <= tx_mode_next;
            if_offset_reg      <= offset_active_next ? if_freq_reg : '0;
            updated_reg        <= acted;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.frequency      = frequency_reg;
    assign out_ch.digit_position = digit_position_reg;
    assign out_ch.transmit       = transmit_reg;
    assign out_ch.if_offset      = if_offset_reg;
    assign out_ch.updated        = updated_reg;

endmodule

>>> hw/rtl/dtkc_checker.sv
module dtkc_checker
    import dtkc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [FREQ_W-1:0]   frequency,
    input logic [CURSOR_W-1:0] digit_position,
    input logic                transmit,
    input logic [IFF_W-1:0]    if_offset
);

    // stalled result keeps its request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frequency)
            && $stable(digit_position) && $stable(transmit))
        else $error("result dropped or changed under stall");

    // cursor never leaves the digit range
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_position <= CURSOR_MAX)
        else $error("digit_position out of range");

    // offset is only reported in receive mode
    a_tx_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transmit |-> if_offset == '0)
        else $error("nonzero offset in transmit mode");

    // a fresh result comes from an accepted request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching request");

endmodule

bind digit_tuning_keypad_controller_core dtkc_checker u_dtkc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .frequency      (out_ch.frequency),
    .digit_position (out_ch.digit_position),
    .transmit       (out_ch.transmit),
    .if_offset      (out_ch.if_offset)
);

>>> tb/sv/tb_digit_tuning_keypad_controller_core.sv
module tb_digit_tuning_keypad_controller_core;
    import dtkc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 6;
    localparam int QUIET_LIMIT     = 4000;
    localparam int PRINT_LIMIT     = 40;

    typedef enum bit {TUNE_DOWN, TUNE_UP} tune_dir_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   frequency;
        logic [CURSOR_W-1:0] digit_position;
        logic                transmit;
        logic [IFF_W-1:0]    if_offset;
        logic                updated;
    } tick_status_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dtkc_in_if  in_ch ();
    dtkc_out_if out_ch ();

    digit_tuning_keypad_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // keypad state as the block should hold it
    logic [FREQ_W-1:0]   kp_freq      = RST_TUNED_FREQ;
    logic [CURSOR_W-1:0] kp_cursor    = '0;
    bit                  kp_tx        = 1'b0;
    bit                  kp_offs_on   = 1'b0;
    logic [BTN_W-1:0]    kp_last      = '0;
    logic [HOLD_W-1:0]   kp_hold      = '0;
    logic [RPT_W-1:0]    kp_rpt_ticks = '0;
    logic [RPT_W-1:0]    kp_rpt_done  = '0;
    logic [FREQ_W-1:0]   kp_max_freq  = RST_MAX_FREQ;
    logic [IFF_W-1:0]    kp_if_freq   = RST_IF_FREQ;

    tick_status_t expected_status[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_off_reqs  = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint unsigned decade_step(input logic [CURSOR_W-1:0] cur);
        longint unsigned p;
        p = 1;
        for (int i = cur; i < DIGITS; i++)
            p = p * 10;
        return p;
    endfunction

    task automatic tune_freq(input tune_dir_t dir);
        longint unsigned stepv;
        longint unsigned sum;
        stepv = decade_step(kp_cursor);
        if (dir == TUNE_UP)
        begin
            sum = longint'(kp_freq) + stepv;
            kp_freq = (sum <= longint'(kp_max_freq)) ? FREQ_W'(sum) : kp_max_freq;
        end
        else
        begin
            kp_freq = (longint'(kp_freq) >= stepv) ? FREQ_W'(longint'(kp_freq) - stepv) : '0;
        end
    endtask

    task automatic advance_keypad(input logic [BTN_W-1:0] btns, output tick_status_t res);
        bit               acted;
        logic [RPT_W-1:0] rpt_delay;
        acted = 1'b0;
        if (btns != kp_last)
        begin
            // repeat_ticks deliberately survives a pattern change
            kp_last     = btns;
            kp_hold     = '0;
            kp_rpt_done = '0;
            if (btns[BTN_UP])
            begin
                tune_freq(TUNE_UP);
                acted = 1'b1;
            end
            else if (btns[BTN_DOWN])
            begin
                tune_freq(TUNE_DOWN);
                acted = 1'b1;
            end
            else if (btns[BTN_RIGHT])
            begin
                if (kp_cursor < CURSOR_MAX)
                    kp_cursor++;
                acted = 1'b1;
            end
            else if (btns[BTN_LEFT])
            begin
                if (kp_cursor != 0)
                    kp_cursor--;
                acted = 1'b1;
            end
            else if (btns[BTN_ENTER])
            begin
                kp_tx      = !kp_tx;
                kp_offs_on = !kp_tx;
                acted      = 1'b1;
            end
        end
        if (btns != 0)
        begin
            if (kp_hold < HOLD_MAX)
                kp_hold++;
            if (kp_hold > HOLD_THRESH)
            begin
                rpt_delay = (kp_rpt_done < FAST_AFTER) ? DELAY_SLOW : DELAY_FAST;
                if (kp_rpt_ticks < RPT_MAX)
                    kp_rpt_ticks++;
                if (kp_rpt_ticks >= rpt_delay)
                begin
                    kp_rpt_ticks = '0;
                    if (kp_rpt_done < RPT_MAX)
                        kp_rpt_done++;
                    if (btns[BTN_UP])
                    begin
                        tune_freq(TUNE_UP);
                        acted = 1'b1;
                    end
                    else if (btns[BTN_DOWN])
                    begin
                        tune_freq(TUNE_DOWN);
                        acted = 1'b1;
                    end
                end
            end
        end
        res.frequency      = kp_freq;
        res.digit_position = kp_cursor;
        res.transmit       = kp_tx;
        res.if_offset      = kp_offs_on ? kp_if_freq : '0;
        res.updated        = acted;
    endtask

    // valid stays high after acceptance; the next call either drives the
    // next request or drops valid for a gap
    task automatic send_tick(input logic [BTN_W-1:0] btns);
        tick_status_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.btn_up    <= btns[BTN_UP];
        in_ch.btn_down  <= btns[BTN_DOWN];
        in_ch.btn_left  <= btns[BTN_LEFT];
        in_ch.btn_right <= btns[BTN_RIGHT];
        in_ch.btn_enter <= btns[BTN_ENTER];
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        advance_keypad(btns, res);
        expected_status.push_back(res);
    endtask

    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_FREQ)
            kp_max_freq = val;
        else
            kp_if_freq = val[IFF_W-1:0];
        @(posedge clk);
    endtask

    // edge actions and priority under the reset settings
    task automatic test_button_actions();
        logic [BTN_W-1:0] seq[$];
        seq = '{5'h01, 5'h00, 5'h02, 5'h1F, 5'h1E, 5'h1C, 5'h14, 5'h04,
                5'h10, 5'h00, 5'h10, 5'h00};
        foreach (seq[i])
            send_tick(seq[i]);
    endtask

    // right walks the cursor to the last digit and once past it
    task automatic test_cursor_sweep();
        for (int i = 0; i < 9; i++)
            send_tick((i % 2) ? 5'h18 : 5'h08);
        send_tick(5'h02);
        send_tick(5'h00);
    endtask

    // zero limit clamps up, floor at zero, offset of zero in receive
    task automatic test_register_limits();
        logic [BTN_W-1:0] seq[$];
        seq = '{5'h01, 5'h02, 5'h00, 5'h10, 5'h00, 5'h10, 5'h00};
        settle_idle();
        write_setting(CFG_MAX_FREQ, '0);
        write_setting(CFG_IF_FREQ, '0);
        foreach (seq[i])
            send_tick(seq[i]);
        settle_idle();
        write_setting(CFG_MAX_FREQ, CFG_DATA_W'(999999999));
        write_setting(CFG_IF_FREQ, CFG_DATA_W'(99999));
        send_tick(5'h10);
        send_tick(5'h00);
    endtask

    // long receiver stall fills the block, then the sender waits for all results
    task automatic test_receiver_hold_off();
        settle_idle();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_off_reqs <= hold_off_reqs + 1;
        repeat (30) send_tick(BTN_W'($urandom_range(0, 31)));
        settle_idle();
        repeat (10) send_tick(BTN_W'($urandom_range(0, 31)));
    endtask

    task automatic test_traffic(input int send_pct, input int recv_pct,
                                input logic [CFG_DATA_W-1:0] max_freq,
                                input logic [CFG_DATA_W-1:0] if_freq, input int n_ticks);
        int               sent;
        int               kind;
        int               len;
        logic [BTN_W-1:0] btns;
        logic [BTN_W-1:0] next_btns;
        settle_idle();
        write_setting(CFG_MAX_FREQ, max_freq);
        write_setting(CFG_IF_FREQ, if_freq);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
        sent = 0;
        while (sent < n_ticks)
        begin
            kind = $urandom_range(0, 99);
            btns = ($urandom_range(0, 3) == 0) ? BTN_W'($urandom_range(1, 31))
                                               : BTN_W'(1 << $urandom_range(0, 4));
            if (kind < 65)
            begin
                // press, hold (sometimes into auto-repeat), release
                len = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 180)
                                                 : $urandom_range(1, 6);
                repeat (len) send_tick(btns);
                sent += len;
                len = $urandom_range(1, 3);
                repeat (len) send_tick('0);
                sent += len;
            end
            else if (kind < 80)
            begin
                // pattern change in the middle of a repeat
                next_btns = BTN_W'($urandom_range(1, 31));
                len = $urandom_range(31, 45);
                repeat (len) send_tick(btns);
                sent += len;
                len = $urandom_range(20, 60);
                repeat (len) send_tick(next_btns);
                sent += len;
                send_tick('0);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len) send_tick(BTN_W'($urandom_range(0, 31)));
                sent += len;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_status
        tick_status_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_status.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = expected_status.pop_front();
                if (out_ch.frequency !== want.frequency)
                    report_mismatch($sformatf("frequency got %0d expected %0d",
                                              out_ch.frequency, want.frequency));
                if (out_ch.digit_position !== want.digit_position)
                    report_mismatch($sformatf("digit_position got %0d expected %0d",
                                              out_ch.digit_position, want.digit_position));
                if (out_ch.transmit !== want.transmit)
                    report_mismatch($sformatf("transmit got %0b expected %0b",
                                              out_ch.transmit, want.transmit));
                if (out_ch.if_offset !== want.if_offset)
                    report_mismatch($sformatf("if_offset got %0d expected %0d",
                                              out_ch.if_offset, want.if_offset));
                if (out_ch.updated !== want.updated)
                    report_mismatch($sformatf("updated got %0b expected %0b",
                                              out_ch.updated, want.updated));
            end
        end
    end

    initial
    begin : receiver
        int stall_left;
        int reqs_served;
        stall_left  = 0;
        reqs_served = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_reqs != reqs_served)
            begin
                reqs_served = hold_off_reqs;
                stall_left  = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_MAX_FREQ;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.btn_up    = 1'b0;
        in_ch.btn_down  = 1'b0;
        in_ch.btn_left  = 1'b0;
        in_ch.btn_right = 1'b0;
        in_ch.btn_enter = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_button_actions();
        test_cursor_sweep();
        test_register_limits();
        test_receiver_hold_off();
        test_traffic(0, 0, CFG_DATA_W'(999999999), CFG_DATA_W'(99999), 440);
        test_traffic(56, 0, CFG_DATA_W'($urandom_range(1000, 150000000)),
                     CFG_DATA_W'($urandom_range(0, 99999)), 440);
        test_traffic(0, 56, CFG_DATA_W'($urandom_range(0, 999999999)),
                     CFG_DATA_W'($urandom_range(0, 99999)), 440);
        test_traffic(10, 10, CFG_DATA_W'(RST_MAX_FREQ), CFG_DATA_W'(RST_IF_FREQ), 440);
        settle_idle();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
